@@ hdl/mutex_table_with_fifo_waiters_defines.svh @@
// assertion macros for the checker file of the mutex table
`ifndef MUTEX_TABLE_WITH_FIFO_WAITERS_DEFINES_SVH
`define MUTEX_TABLE_WITH_FIFO_WAITERS_DEFINES_SVH

// clocked check, muted while reset is asserted
`define MTFW_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also holds while reset is asserted
`define MTFW_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/mtfw_pkg.sv @@
// types, codes and defaults of the mutex table with fifo waiters
`default_nettype none

package mtfw_pkg;

	localparam int NUM_MUTEXES_DEF = 32;
	localparam int NUM_TASKS_DEF   = 64;

	localparam int CMD_W  = 2;
	localparam int ID_W   = 6;
	localparam int ST_W   = 3;
	localparam int CID_W  = 5;

	localparam logic [ID_W-1:0] NO_TASK = 6'd63;

	localparam logic [CMD_W-1:0] CMD_CREATE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOCK   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_UNLOCK = 2'd2;

	localparam logic [ST_W-1:0] ST_OK       = 3'd0;
	localparam logic [ST_W-1:0] ST_BLOCKED  = 3'd1;
	localparam logic [ST_W-1:0] ST_NOFREE   = 3'd2;
	localparam logic [ST_W-1:0] ST_INVALID  = 3'd3;
	localparam logic [ST_W-1:0] ST_DEADLOCK = 3'd4;
	localparam logic [ST_W-1:0] ST_NOPERM   = 3'd5;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [ID_W-1:0]  mutex_id;
		logic [ID_W-1:0]  task_prio;
	} req_t;

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic [CID_W-1:0] created_id;
		logic             wake_valid;
		logic [ID_W-1:0]  wake_task;
	} rsp_t;

	// one mutex table entry
	typedef struct packed {
		logic [ID_W-1:0] holder;
		logic [ID_W-1:0] head;
		logic [ID_W-1:0] tail;
	} mword_t;

	localparam int MWORD_W = $bits(mword_t);

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic eval;
		logic link;
		logic load_out;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic need_link;
	} stat_t;

endpackage

`default_nettype wire

@@ hdl/mtfw_ram.sv @@
// generic single write port ram with registered read
`default_nettype none

module mtfw_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 32,
	parameter int ADDR_W = 5
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ hdl/mtfw_ctrl.sv @@
// controller state machine and output valid of the mutex table
`default_nettype none

module mtfw_ctrl import mtfw_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  req_valid,
	output logic       req_ready,
	output logic       rsp_valid,
	input  wire logic  rsp_ready,
	input  wire stat_t stat,
	output ctl_t       ctl
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EVAL = 4'b0010,
		S_LINK = 4'b0100,
		S_RESP = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   rsp_valid_q;
	logic   slot_free;

	assign slot_free    = !rsp_valid_q || rsp_ready;
	assign req_ready    = (state_q == S_IDLE);
	assign rsp_valid    = rsp_valid_q;

	assign ctl.capture  = req_valid && req_ready;
	assign ctl.eval     = (state_q == S_EVAL);
	assign ctl.link     = (state_q == S_LINK);
	assign ctl.load_out = (state_q == S_RESP) && slot_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_EVAL;
			end
			S_EVAL: begin
				state_d = stat.need_link ? S_LINK : S_RESP;
			end
			S_LINK: begin
				state_d = S_RESP;
			end
			S_RESP: begin
				if (slot_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/mtfw_dp.sv @@
// datapath: mutex table, task links, decision logic and output register
`default_nettype none

module mtfw_dp import mtfw_pkg::*; #(
	parameter int NUM_MUTEXES = NUM_MUTEXES_DEF,
	parameter int NUM_TASKS   = NUM_TASKS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire ctl_t ctl,
	input  wire req_t req,
	output stat_t     stat,
	output rsp_t      rsp
);

	localparam int MW = (NUM_MUTEXES > 1) ? $clog2(NUM_MUTEXES) : 1;
	localparam int TW = $clog2(NUM_TASKS);
	localparam int CW = $clog2(NUM_MUTEXES + 1);

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_CREATE,
		ACT_GRANT,
		ACT_RELEASE,
		ACT_QUEUE,
		ACT_POP
	} act_t;

	// captured request
	logic [CMD_W-1:0] cmd_q;
	logic [ID_W-1:0]  mid_q;
	logic [ID_W-1:0]  tid_q;

	// allocation only ever takes the lowest free entry, so entries below count are allocated
	logic [CW-1:0] count_q;

	logic [NUM_MUTEXES-1:0] mvalid_q;
	logic [NUM_TASKS-1:0]   nvalid_q;
	logic                   mval_q;
	logic                   nval_q;

	act_t   act_q, act_d;
	mword_t word_q, cur;
	rsp_t   res_q, res_d, rsp_q;

	logic               m_we;
	logic [MW-1:0]      m_waddr;
	mword_t             m_wdata;
	logic [MWORD_W-1:0] m_rdata;

	logic            n_we;
	logic [TW-1:0]   n_waddr;
	logic [ID_W-1:0] n_wdata;
	logic            n_re;
	logic [TW-1:0]   n_raddr;
	logic [ID_W-1:0] n_rdata;
	logic [ID_W-1:0] next_head;

	logic idx_ok, alloc_ok, task_ok, room;

	mtfw_ram #(
		.WIDTH (MWORD_W),
		.DEPTH (NUM_MUTEXES),
		.ADDR_W(MW)
	) u_mtab (
		.clk  (clk),
		.we   (m_we),
		.waddr(m_waddr),
		.wdata(m_wdata),
		.re   (ctl.capture),
		.raddr(req.mutex_id[MW-1:0]),
		.rdata(m_rdata)
	);

	mtfw_ram #(
		.WIDTH (ID_W),
		.DEPTH (NUM_TASKS),
		.ADDR_W(TW)
	) u_links (
		.clk  (clk),
		.we   (n_we),
		.waddr(n_waddr),
		.wdata(n_wdata),
		.re   (n_re),
		.raddr(n_raddr),
		.rdata(n_rdata)
	);

	// entries never written read as empty
	assign cur       = mval_q ? mword_t'(m_rdata) : mword_t'{NO_TASK, NO_TASK, NO_TASK};
	assign next_head = nval_q ? n_rdata : NO_TASK;

	assign idx_ok   = {1'b0, mid_q} < (ID_W + 1)'(NUM_MUTEXES);
	assign alloc_ok = {1'b0, mid_q} < (ID_W + 1)'(count_q);
	assign task_ok  = (tid_q != NO_TASK) && ({1'b0, tid_q} < (ID_W + 1)'(NUM_TASKS));
	assign room     = count_q < CW'(NUM_MUTEXES);

	assign stat.need_link = (act_d == ACT_QUEUE) || (act_d == ACT_POP);
	assign rsp            = rsp_q;

	// decision on the captured request
	always_comb begin
		act_d = ACT_NONE;
		res_d = '{ST_INVALID, '0, 1'b0, NO_TASK};
		case (cmd_q) inside
			CMD_CREATE: begin
				if (room) begin
					act_d            = ACT_CREATE;
					res_d.status     = ST_OK;
					res_d.created_id = CID_W'(count_q);
				end else begin
					res_d.status = ST_NOFREE;
				end
			end
			CMD_LOCK, CMD_UNLOCK: begin
				if (idx_ok && alloc_ok && task_ok) begin
					if (cmd_q == CMD_LOCK) begin
						if (cur.holder == NO_TASK) begin
							act_d        = ACT_GRANT;
							res_d.status = ST_OK;
						end else if (cur.holder == tid_q) begin
							res_d.status = ST_DEADLOCK;
						end else begin
							act_d        = ACT_QUEUE;
							res_d.status = ST_BLOCKED;
						end
					end else begin
						if (cur.holder != tid_q) begin
							res_d.status = ST_NOPERM;
						end else if (cur.head == NO_TASK) begin
							act_d        = ACT_RELEASE;
							res_d.status = ST_OK;
						end else begin
							act_d            = ACT_POP;
							res_d.status     = ST_OK;
							res_d.wake_valid = 1'b1;
							res_d.wake_task  = cur.head;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	// table and link writes; a queued lock clears its own link first, then joins the tail
	always_comb begin
		m_we    = 1'b0;
		m_waddr = mid_q[MW-1:0];
		m_wdata = cur;
		n_we    = 1'b0;
		n_waddr = tid_q[TW-1:0];
		n_wdata = NO_TASK;
		n_re    = 1'b0;
		n_raddr = cur.head[TW-1:0];
		if (ctl.eval) begin
			case (act_d)
				ACT_GRANT: begin
					m_we           = 1'b1;
					m_wdata.holder = tid_q;
				end
				ACT_RELEASE: begin
					m_we           = 1'b1;
					m_wdata.holder = NO_TASK;
				end
				ACT_QUEUE: begin
					n_we = 1'b1;
				end
				ACT_POP: begin
					n_re = 1'b1;
				end
				default: begin
				end
			endcase
		end else if (ctl.link) begin
			m_wdata = word_q;
			case (act_q)
				ACT_QUEUE: begin
					m_we         = 1'b1;
					m_wdata.tail = tid_q;
					if (word_q.head == NO_TASK) begin
						m_wdata.head = tid_q;
					end else begin
						n_we    = 1'b1;
						n_waddr = word_q.tail[TW-1:0];
						n_wdata = tid_q;
					end
				end
				ACT_POP: begin
					m_we           = 1'b1;
					m_wdata.holder = NO_TASK;
					m_wdata.head   = next_head;
					if (next_head == NO_TASK) m_wdata.tail = NO_TASK;
					n_we    = 1'b1;
					n_waddr = word_q.head[TW-1:0];
					n_wdata = NO_TASK;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			mvalid_q <= '0;
			nvalid_q <= '0;
			act_q    <= ACT_NONE;
		end else begin
			if (ctl.eval) begin
				act_q <= act_d;
				if (act_d == ACT_CREATE) count_q <= count_q + CW'(1);
			end
			if (m_we) mvalid_q[m_waddr] <= 1'b1;
			if (n_we) nvalid_q[n_waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q  <= req.command;
			mid_q  <= req.mutex_id;
			tid_q  <= req.task_prio;
			mval_q <= mvalid_q[req.mutex_id[MW-1:0]];
		end
		if (n_re) nval_q <= nvalid_q[n_raddr];
		if (ctl.eval) begin
			word_q <= cur;
			res_q  <= res_d;
		end
		if (ctl.load_out) rsp_q <= res_q;
	end

endmodule

`default_nettype wire

@@ hdl/mutex_table_with_fifo_waiters.sv @@
// top level of the mutex table with fifo waiter queues
//
//  channel | handshake             | word   | fields
//  --------+-----------------------+--------+-------------------------------------------
//  req     | req_valid / req_ready | req_t  | command, mutex_id, task_prio
//  rsp     | rsp_valid / rsp_ready | rsp_t  | status, created_id, wake_valid, wake_task
//
//  one request word is worked on at a time; it gives exactly one response word
//  create, deadlock, grant, release without waiters and rejects pass through evaluate and
//  response before the next accept, queued lock and unlock with wake-up also pass link
//  the link state is a second pass over the task link ram: the tail link write of a
//  queued lock, or the registered read of the head waiter's link on a wake-up
//  a response left waiting on rsp_ready holds the block in its last state until taken
//  reset clears the state machine, the allocation count and the table valid bits
`default_nettype none

module mutex_table_with_fifo_waiters import mtfw_pkg::*; #(
	parameter int NUM_MUTEXES = NUM_MUTEXES_DEF,
	parameter int NUM_TASKS   = NUM_TASKS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	// command and status between controller and datapath
	ctl_t  ctl;
	stat_t stat;

	// sequencing: capture, evaluate, link update, response load
	mtfw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.stat     (stat),
		.ctl      (ctl)
	);

	// mutex table ram, task link ram, allocation count and response register
	mtfw_dp #(
		.NUM_MUTEXES(NUM_MUTEXES),
		.NUM_TASKS  (NUM_TASKS)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl),
		.req   (req),
		.stat  (stat),
		.rsp   (rsp)
	);

endmodule

`default_nettype wire

@@ hdl/mtfw_checker.sv @@
// port level checks of the mutex table and their bind
`default_nettype none

`include "mutex_table_with_fifo_waiters_defines.svh"

module mtfw_checker import mtfw_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire req_t req,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire rsp_t rsp
);

	// a pending response word holds
	`MTFW_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp), "response changed while stalled")

	// one word in flight: no accept right after an accept
	`MTFW_ASSERT(a_one_in_flight, req_valid && req_ready |=> !req_ready, "request accepted while busy")

	// a new response only follows a cycle of work
	`MTFW_ASSERT(a_rsp_after_work, $rose(rsp_valid) |-> $past(!req_ready), "response without work")

	// a wake-up only comes with a successful unlock
	`MTFW_ASSERT(a_wake_ok, rsp_valid && rsp.wake_valid |-> rsp.status == ST_OK && rsp.wake_task != NO_TASK, "bad wake")

	// no response in the cycle after one spent in reset
	`MTFW_ASSERT_RST(a_reset_quiet, !arst_n |=> !rsp_valid, "response during reset")

endmodule

bind mutex_table_with_fifo_waiters mtfw_checker u_chk (.*);

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// self-checking bench for the mutex table: directed table, then random lock traffic
module tb_top;

	import mtfw_pkg::*;

	localparam int MUTEXES      = NUM_MUTEXES_DEF;
	localparam int TASKS        = NUM_TASKS_DEF;
	localparam int RANDOM_WORDS = 1030;
	localparam int STUCK_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 10;
	localparam int SHOWN_ERRORS = 10;

	// the one command code the package leaves unnamed
	localparam logic [CMD_W-1:0] CMD_UNDEF = 2'd3;

	// one row of the directed table; sure rows carry a hand-typed reply
	typedef struct packed {
		req_t rq;
		logic sure;
		rsp_t reply;
	} dir_row_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	// bench copy of the lock table
	logic            mx_alloc  [MUTEXES];
	logic            mx_locked [MUTEXES];
	logic [ID_W-1:0] mx_holder [MUTEXES];
	logic [ID_W-1:0] mx_head   [MUTEXES];
	logic [ID_W-1:0] mx_tail   [MUTEXES];
	logic [ID_W-1:0] task_link [TASKS];
	logic            task_holds[TASKS];

	// stimulus bookkeeping: who sits in a queue, who was woken and must retry
	logic            waiting   [TASKS];
	logic [11:0]     retry_q[$];

	rsp_t            reply_q[$];      // replies still owed by the block
	dir_row_t        dir_rows[$];

	logic req_gaps = 1'b0;
	logic rsp_gaps = 1'b0;
	int   errors     = 0;
	int   words_sent = 0;
	int   words_back = 0;
	int   wakes      = 0;
	int   stuck      = 0;
	int   status_cnt[8];

	mutex_table_with_fifo_waiters i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// applies one request word to the bench table and returns the reply it owes
	function automatic rsp_t lock_table_step(req_t rq);
		rsp_t            r;
		int              mi;
		logic [ID_W-1:0] t;
		logic [ID_W-1:0] w;
		logic            found;
		r.status     = ST_INVALID;
		r.created_id = '0;
		r.wake_valid = 1'b0;
		r.wake_task  = NO_TASK;
		mi    = int'(rq.mutex_id);
		t     = rq.task_prio;
		found = 1'b0;
		case (rq.command)
			CMD_CREATE: begin
				// lowest free entry wins, the other fields are ignored
				r.status = ST_NOFREE;
				for (int i = 0; i < MUTEXES; i++) begin
					if (!found && !mx_alloc[i]) begin
						found        = 1'b1;
						mx_alloc[i]  = 1'b1;
						r.status     = ST_OK;
						r.created_id = CID_W'(i);
					end
				end
			end
			CMD_LOCK, CMD_UNLOCK: begin
				// index first, then allocation, then the task number
				if (mi < MUTEXES) begin
					if (mx_alloc[mi] && t != NO_TASK && int'(t) < TASKS) begin
						if (rq.command == CMD_LOCK) begin
							if (!mx_locked[mi]) begin
								mx_locked[mi] = 1'b1;
								mx_holder[mi] = t;
								task_holds[t] = 1'b1;
								r.status      = ST_OK;
							end else if (mx_holder[mi] == t) begin
								r.status = ST_DEADLOCK;
							end else begin
								// append at the tail; a task already queued gets relinked
								task_link[t] = NO_TASK;
								if (mx_head[mi] == NO_TASK) begin
									mx_head[mi] = t;
								end else begin
									task_link[mx_tail[mi]] = t;
								end
								mx_tail[mi] = t;
								r.status    = ST_BLOCKED;
							end
						end else if (!mx_locked[mi] || mx_holder[mi] != t) begin
							r.status = ST_NOPERM;
						end else begin
							task_holds[t] = 1'b0;
							mx_locked[mi] = 1'b0;
							mx_holder[mi] = NO_TASK;
							r.status      = ST_OK;
							w             = mx_head[mi];
							if (w != NO_TASK) begin
								// pop the head waiter, the queue may drain empty
								r.wake_valid = 1'b1;
								r.wake_task  = w;
								mx_head[mi]  = task_link[w];
								task_link[w] = NO_TASK;
								if (mx_head[mi] == NO_TASK) begin
									mx_tail[mi] = NO_TASK;
								end
							end
						end
					end
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic dir_row_t ask(logic [CMD_W-1:0] c, int m, int t);
		dir_row_t d;
		d.rq.command   = c;
		d.rq.mutex_id  = ID_W'(m);
		d.rq.task_prio = ID_W'(t);
		d.sure         = 1'b0;
		d.reply        = '0;
		return d;
	endfunction

	function automatic dir_row_t ask_sure(logic [CMD_W-1:0] c, int m, int t,
			logic [ST_W-1:0] st, int cid, logic wv, int wt);
		dir_row_t d;
		d                  = ask(c, m, t);
		d.sure             = 1'b1;
		d.reply.status     = st;
		d.reply.created_id = CID_W'(cid);
		d.reply.wake_valid = wv;
		d.reply.wake_task  = ID_W'(wt);
		return d;
	endfunction

	// mostly a few hot mutexes so that queues build up
	function automatic int pick_mutex();
		int alloc_n;
		alloc_n = 0;
		for (int i = 0; i < MUTEXES; i++) begin
			if (mx_alloc[i]) begin
				alloc_n++;
			end
		end
		if (alloc_n == 0) begin
			return $urandom_range(0, 63);
		end
		if ($urandom_range(0, 9) < 7) begin
			return $urandom_range(0, (alloc_n < 4 ? alloc_n : 4) - 1);
		end
		return $urandom_range(0, alloc_n - 1);
	endfunction

	// small task pool for contention, now and then any valid task
	function automatic int pick_task();
		if ($urandom_range(0, 9) < 8) begin
			return $urandom_range(0, 7);
		end
		return $urandom_range(0, 62);
	endfunction

	// drives one request word, waits for its accept and books the owed reply
	task automatic send_word(input req_t rq, input logic sure, input rsp_t sure_rsp);
		int   gap;
		rsp_t pred;
		if (words_sent % 64 == 0) begin
			req_gaps = $urandom_range(0, 3) != 0;
		end
		gap = req_gaps ? $urandom_range(0, 10) : 0;
		repeat (gap) @(negedge clk) req_valid <= 1'b0;
		@(negedge clk);
		req_valid <= 1'b1;
		req       <= rq;
		do @(posedge clk); while (!(req_valid && req_ready));
		pred = lock_table_step(rq);
		reply_q.push_back(sure ? sure_rsp : pred);
		status_cnt[pred.status]++;
		words_sent++;
		// feed the generator: queued tasks sit out, woken tasks come back
		if (rq.command == CMD_LOCK && pred.status == ST_BLOCKED) begin
			waiting[rq.task_prio] = 1'b1;
		end
		if (pred.wake_valid) begin
			wakes++;
			waiting[pred.wake_task] = 1'b0;
			retry_q.push_back({rq.mutex_id, pred.wake_task});
		end
	endtask

	// request side: reset, directed table, random traffic, drain, verdict
	initial begin
		req_t     rq;
		int       pick;
		int       mi;
		int       ti;
		int       held[$];
		for (int i = 0; i < MUTEXES; i++) begin
			mx_alloc[i]  = 1'b0;
			mx_locked[i] = 1'b0;
			mx_holder[i] = NO_TASK;
			mx_head[i]   = NO_TASK;
			mx_tail[i]   = NO_TASK;
		end
		for (int i = 0; i < TASKS; i++) begin
			task_link[i]  = NO_TASK;
			task_holds[i] = 1'b0;
			waiting[i]    = 1'b0;
		end
		for (int i = 0; i < 8; i++) begin
			status_cnt[i] = 0;
		end

		// rejects on an empty table, then one mutex walked through its life
		dir_rows.push_back(ask_sure(CMD_LOCK,   0,  1,  ST_INVALID,  0, 1'b0, NO_TASK));
		dir_rows.push_back(ask_sure(CMD_UNLOCK, 63, 62, ST_INVALID,  0, 1'b0, NO_TASK));
		dir_rows.push_back(ask_sure(CMD_LOCK,   32, 0,  ST_INVALID,  0, 1'b0, NO_TASK));
		dir_rows.push_back(ask_sure(CMD_UNDEF,  63, 63, ST_INVALID,  0, 1'b0, NO_TASK));
		dir_rows.push_back(ask_sure(CMD_CREATE, 63, 63, ST_OK,       0, 1'b0, NO_TASK));
		dir_rows.push_back(ask_sure(CMD_CREATE, 0,  0,  ST_OK,       1, 1'b0, NO_TASK));
		dir_rows.push_back(ask_sure(CMD_LOCK,   0,  63, ST_INVALID,  0, 1'b0, NO_TASK));
		dir_rows.push_back(ask_sure(CMD_LOCK,   0,  0,  ST_OK,       0, 1'b0, NO_TASK));
		dir_rows.push_back(ask_sure(CMD_LOCK,   0,  0,  ST_DEADLOCK, 0, 1'b0, NO_TASK));
		dir_rows.push_back(ask_sure(CMD_LOCK,   0,  62, ST_BLOCKED,  0, 1'b0, NO_TASK));
		dir_rows.push_back(ask_sure(CMD_LOCK,   0,  5,  ST_BLOCKED,  0, 1'b0, NO_TASK));
		dir_rows.push_back(ask_sure(CMD_UNLOCK, 0,  5,  ST_NOPERM,   0, 1'b0, NO_TASK));
		dir_rows.push_back(ask_sure(CMD_UNLOCK, 1,  0,  ST_NOPERM,   0, 1'b0, NO_TASK));
		// task 0 holds two mutexes, wake-ups, a waiter queued twice
		dir_rows.push_back(ask(CMD_LOCK,   1,  0));
		dir_rows.push_back(ask(CMD_UNLOCK, 0,  0));
		dir_rows.push_back(ask(CMD_LOCK,   0,  62));
		dir_rows.push_back(ask(CMD_LOCK,   0,  5));
		dir_rows.push_back(ask(CMD_UNLOCK, 1,  0));
		dir_rows.push_back(ask(CMD_UNLOCK, 0,  62));
		dir_rows.push_back(ask(CMD_LOCK,   0,  5));
		dir_rows.push_back(ask(CMD_UNLOCK, 0,  5));
		dir_rows.push_back(ask(CMD_CREATE, 0,  0));

		repeat (2) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			send_word(dir_rows[i].rq, dir_rows[i].sure, dir_rows[i].reply);
		end

		// random part: creates fill the table early, then lock and unlock sequences
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			pick = $urandom_range(0, 99);
			ti   = pick_task();
			repeat (4) begin
				if (waiting[ti]) begin
					ti = pick_task();
				end
			end
			rq.command   = CMD_LOCK;
			rq.mutex_id  = ID_W'(pick_mutex());
			rq.task_prio = ID_W'(ti);
			if (pick < 8) begin
				rq.command   = CMD_CREATE;
				rq.mutex_id  = ID_W'($urandom);
				rq.task_prio = ID_W'($urandom);
			end else if (pick < 48) begin
				// a woken task usually retries its lock first
				if (retry_q.size() > 0 && $urandom_range(0, 3) != 0) begin
					{rq.mutex_id, rq.task_prio} = retry_q.pop_front();
				end
			end else if (pick < 88) begin
				// release by the holder, rarely by someone else
				held.delete();
				for (int k = 0; k < MUTEXES; k++) begin
					if (mx_alloc[k] && mx_locked[k]) begin
						held.push_back(k);
					end
				end
				if (held.size() > 0) begin
					mi           = held[$urandom_range(0, held.size() - 1)];
					rq.command   = CMD_UNLOCK;
					rq.mutex_id  = ID_W'(mi);
					rq.task_prio = ($urandom_range(0, 9) == 0) ? ID_W'(pick_task())
						: mx_holder[mi];
				end
			end else begin
				// raw noise over every field bit
				rq.command   = CMD_W'($urandom);
				rq.mutex_id  = ID_W'($urandom);
				rq.task_prio = ID_W'($urandom);
			end
			send_word(rq, 1'b0, '0);
		end

		@(negedge clk) req_valid <= 1'b0;
		while (reply_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d request words: %0d ok, %0d queued, %0d deadlock, %0d no free, %0d invalid,",
			words_sent, status_cnt[ST_OK], status_cnt[ST_BLOCKED], status_cnt[ST_DEADLOCK],
			status_cnt[ST_NOFREE], status_cnt[ST_INVALID]);
		$display("%0d not permitted, %0d wake-ups, %0d reply words checked, %0d errors",
			status_cnt[ST_NOPERM], wakes, words_back, errors);
		if (errors == 0) begin
			$display("mutex_table_with_fifo_waiters regression: pass");
		end else begin
			$display("mutex_table_with_fifo_waiters regression: fail");
		end
		$finish;
	end

	// reply side: random back-pressure, each reply word checked against the oldest owed one
	initial begin
		int   stall;
		rsp_t want;
		forever begin
			if (words_back % 64 == 0) begin
				rsp_gaps = $urandom_range(0, 3) != 0;
			end
			stall = rsp_gaps ? $urandom_range(0, 10) : 0;
			repeat (stall) @(negedge clk) rsp_ready <= 1'b0;
			@(negedge clk) rsp_ready <= 1'b1;
			do @(posedge clk); while (!(rsp_valid && rsp_ready));
			words_back++;
			if (reply_q.size() == 0) begin
				errors++;
				if (errors <= SHOWN_ERRORS) begin
					$display("unexpected reply word: status %0d cid %0d wake %0b task %0d",
						rsp.status, rsp.created_id, rsp.wake_valid, rsp.wake_task);
				end
			end else begin
				want = reply_q.pop_front();
				if (rsp !== want) begin
					errors++;
					if (errors <= SHOWN_ERRORS) begin
						$display("reply word %0d: got status %0d cid %0d wake %0b task %0d",
							words_back, rsp.status, rsp.created_id, rsp.wake_valid,
							rsp.wake_task);
						$display("  want status %0d cid %0d wake %0b task %0d",
							want.status, want.created_id, want.wake_valid, want.wake_task);
					end
				end
			end
		end
	end

	// watchdog: too long without a word moving on either side
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			stuck <= 0;
		end else begin
			stuck <= stuck + 1;
		end
		if (stuck >= STUCK_LIMIT) begin
			$display("mutex_table_with_fifo_waiters regression: fail");
			$finish;
		end
	end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/mtfw_pkg.sv
hdl/mtfw_ram.sv
hdl/mtfw_ctrl.sv
hdl/mtfw_dp.sv
hdl/mutex_table_with_fifo_waiters.sv
hdl/mtfw_checker.sv
tb/tb_top.sv
